### src/vrym_pkg.sv
package vrym_pkg;

   localparam int STILL_LIMIT = 32;
   localparam int STILL_SAT   = 255;

   localparam int PULSE_MIN   = 850;
   localparam int PULSE_MAX   = 2200;
   localparam int DEAD_LO     = 1480;
   localparam int DEAD_HI     = 1520;
   localparam int PULSE_MID   = 1500;
   localparam int STEER_OFS   = 50154;
   localparam int STEER_SLOPE = 33;
   localparam int STEER_GAIN  = 3217;
   localparam int STEER_DIV   = 180;
   localparam int K1_GAIN     = 13;
   localparam int K2_NUM      = 654;
   localparam int K4_NUM      = 8;
   localparam int K5_OFS      = 186;
   localparam int K5_GAIN     = 3;

   // serial multiplier: 34-bit signed x 22-bit signed
   localparam int MA_W      = 34;
   localparam int MB_W      = 22;
   localparam int MP_W      = MA_W + MB_W + 1;
   localparam int MUL_STEPS = MB_W;

   // serial divider: 46-bit signed dividend, 44-bit signed divisor
   localparam int DN_W      = 46;
   localparam int DD_W      = 44;
   localparam int DIV_STEPS = 45;

   typedef enum logic [12:0] {
      S_IDLE = 13'b0000000000001,
      S_VEL  = 13'b0000000000010,
      S_MT   = 13'b0000000000100,
      S_D180 = 13'b0000000001000,
      S_VV   = 13'b0000000010000,
      S_K2   = 13'b0000000100000,
      S_K4   = 13'b0000001000000,
      S_K5   = 13'b0000010000000,
      S_KD   = 13'b0000100000000,
      S_ND   = 13'b0001000000000,
      S_NS   = 13'b0010000000000,
      S_DY   = 13'b0100000000000,
      S_FIN  = 13'b1000000000000
   } state_type;

   // divide by 2**k, halves rounded away from zero
   function automatic logic signed [63:0] rshr(input logic signed [63:0] n,
                                               input int unsigned k);
      logic [63:0] m;
      logic [63:0] r;
      m = n[63] ? 64'(-n) : 64'(n);
      r = (m + (64'd1 << (k - 1))) >> k;
      rshr = n[63] ? -$signed(r) : $signed(r);
   endfunction

   function automatic logic signed [63:0] satr(input logic signed [63:0] x,
                                               input logic signed [63:0] lo,
                                               input logic signed [63:0] hi);
      if (x < lo) satr = lo;
      else if (x > hi) satr = hi;
      else satr = x;
   endfunction

   localparam logic signed [63:0] I32_MIN = -64'sd2147483648;
   localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] V_MIN   = -64'sd2097152;
   localparam logic signed [63:0] V_MAX   = 64'sd2097151;

endpackage

### src/vrym_mul.sv
module vrym_mul (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [vrym_pkg::MA_W-1:0]    a,
   input  logic signed [vrym_pkg::MB_W-1:0]    b,
   output logic                                done,
   output logic signed [vrym_pkg::MP_W-1:0]    prod
);

   localparam int AW = vrym_pkg::MA_W;
   localparam int BW = vrym_pkg::MB_W;
   localparam int SW = AW + BW;

   logic [SW-1:0] sh_ff, sh_in;
   logic [SW-1:0] acc_ff, acc_in;
   logic [BW-1:0] bm_ff, bm_in;
   logic          neg_ff;
   logic [4:0]    cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic signed [vrym_pkg::MP_W-1:0] prod_ff;

   logic [AW-1:0] am;
   logic [BW-1:0] bm;

   always_comb begin
      am     = a[AW-1] ? AW'(-a) : AW'(a);
      bm     = b[BW-1] ? BW'(-b) : BW'(b);
      acc_in = bm_ff[0] ? acc_ff + sh_ff : acc_ff;
      sh_in  = sh_ff << 1;
      bm_in  = bm_ff >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'(vrym_pkg::MUL_STEPS);
         end else if (busy_ff) begin
            if (cnt_ff != '0) begin
               cnt_ff <= cnt_ff - 5'd1;
            end else begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         sh_ff  <= SW'(am);
         bm_ff  <= bm;
         acc_ff <= '0;
         neg_ff <= a[AW-1] ^ b[BW-1];
      end else if (busy_ff && cnt_ff != '0) begin
         sh_ff  <= sh_in;
         bm_ff  <= bm_in;
         acc_ff <= acc_in;
      end else if (busy_ff) begin
         prod_ff <= neg_ff ? -$signed(vrym_pkg::MP_W'(acc_ff))
                           : $signed(vrym_pkg::MP_W'(acc_ff));
      end
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

### src/vrym_div.sv
module vrym_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [vrym_pkg::DN_W-1:0]  num,
   input  logic signed [vrym_pkg::DD_W-1:0]  den,
   output logic                              done,
   output logic signed [vrym_pkg::DN_W-1:0]  quot
);

   localparam int NW = vrym_pkg::DN_W;
   localparam int DW = vrym_pkg::DD_W;
   localparam int MW = vrym_pkg::DIV_STEPS;

   logic [MW-1:0] nm_ff, nm_in;
   logic [DW-1:0] dm_ff;
   logic [MW-1:0] rem_ff, rem_in;
   logic [MW-1:0] q_ff, q_in;
   logic          neg_ff;
   logic [5:0]    cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic signed [NW-1:0] quot_ff;

   logic [DW-1:0]        dm;
   logic signed [NW:0]   hs;
   logic signed [NW:0]   np;
   logic [MW-1:0]        nm;
   logic [MW-1:0]        r2;
   logic                 ge;

   always_comb begin
      dm = den[DW-1] ? DW'(-den) : DW'(den);
      hs = (den[DW-1] ^ num[NW-1]) ? -$signed((NW+1)'(dm >> 1))
                                   : $signed((NW+1)'(dm >> 1));
      np = (NW+1)'(num) + hs;
      nm = np[NW] ? MW'(-np) : MW'(np);
      r2 = {rem_ff[MW-2:0], nm_ff[MW-1]};
      ge = r2 >= MW'(dm_ff);
      rem_in = ge ? r2 - MW'(dm_ff) : r2;
      q_in   = {q_ff[MW-2:0], ge};
      nm_in  = nm_ff << 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'(vrym_pkg::DIV_STEPS);
         end else if (busy_ff) begin
            if (cnt_ff != '0) begin
               cnt_ff <= cnt_ff - 6'd1;
            end else begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         nm_ff  <= nm;
         dm_ff  <= dm;
         rem_ff <= '0;
         q_ff   <= '0;
         neg_ff <= np[NW] ^ den[DW-1];
      end else if (busy_ff && cnt_ff != '0) begin
         nm_ff  <= nm_in;
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end else if (busy_ff) begin
         quot_ff <= neg_ff ? -$signed(NW'(q_ff)) : $signed(NW'(q_ff));
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

### src/velocity_and_reference_yaw_model_top.sv
// Velocity and reference yaw model. One request is worked at a time. A
// request with zero normalized velocity passes S_VEL to S_FIN and goes
// idle without the arithmetic units. Any other request runs five
// divisions on the bit-serial divider and four products on the
// bit-serial multiplier, which all steps share in turn; a zero
// denominator skips the last product and division. A result waits in an
// output register, so the next request is taken while it is stalled.
module velocity_and_reference_yaw_model_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [20:0] req_accel_sample,
   input  logic [11:0]        req_steering_pulse,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [21:0] rsp_velocity,
   output logic signed [31:0] rsp_reference_yaw,
   output logic signed [31:0] rsp_yaw_numerator,
   output logic signed [31:0] rsp_yaw_denominator,
   output logic               rsp_model_invalid
);

   localparam int AW = vrym_pkg::MA_W;
   localparam int BW = vrym_pkg::MB_W;
   localparam int NW = vrym_pkg::DN_W;
   localparam int DW = vrym_pkg::DD_W;

   vrym_pkg::state_type state_ff;
   logic                launch_ff;

   logic signed [20:0] prev_ff;
   logic signed [31:0] raw_ff;
   logic [7:0]         sc_ff;
   logic signed [31:0] y0_ff, y1_ff;

   logic [11:0]        p_ff;
   logic signed [21:0] v_ff;
   logic signed [32:0] dyaw_ff;
   logic signed [10:0] steer_ff;
   logic signed [43:0] vv_ff;
   logic signed [10:0] k2_ff;
   logic signed [4:0]  k4_ff;
   logic signed [9:0]  k5_ff;
   logic signed [31:0] num_ff, den_ff, yaw_ff;
   logic               inv_ff;

   logic               rsp_valid_ff;
   logic signed [21:0] rsp_vel_ff;
   logic signed [31:0] rsp_yaw_ff, rsp_num_ff, rsp_den_ff;
   logic               rsp_inv_ff;

   logic               accept, out_free;
   logic [7:0]         sc_in;
   logic signed [31:0] raw_in;
   logic [11:0]        p_in;
   logic signed [63:0] tr, v_in, k13;
   logic signed [33:0] x_w;

   logic                  mul_start, mul_done;
   logic signed [AW-1:0]  mul_a;
   logic signed [BW-1:0]  mul_b;
   logic signed [vrym_pkg::MP_W-1:0] mul_p;
   logic                  div_start, div_done;
   logic signed [NW-1:0]  div_n;
   logic signed [DW-1:0]  div_d;
   logic signed [NW-1:0]  div_q;
   logic                  mul_st, div_st;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != vrym_pkg::S_IDLE;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (req_accel_sample == '0) begin
         sc_in = (sc_ff == 8'(vrym_pkg::STILL_SAT)) ? sc_ff : sc_ff + 8'd1;
      end else begin
         sc_in = '0;
      end
      tr = 64'(raw_ff) + 64'(prev_ff)
         + vrym_pkg::rshr(64'(req_accel_sample) - 64'(prev_ff), 1);
      if (sc_in >= 8'(vrym_pkg::STILL_LIMIT)) begin
         raw_in = '0;
      end else begin
         raw_in = 32'(vrym_pkg::satr(tr, vrym_pkg::I32_MIN, vrym_pkg::I32_MAX));
      end
      p_in = req_steering_pulse;
      if (req_steering_pulse < 12'(vrym_pkg::PULSE_MIN)
          || req_steering_pulse > 12'(vrym_pkg::PULSE_MAX)
          || (req_steering_pulse > 12'(vrym_pkg::DEAD_LO)
              && req_steering_pulse < 12'(vrym_pkg::DEAD_HI))) begin
         p_in = 12'(vrym_pkg::PULSE_MID);
      end
      v_in = vrym_pkg::satr(vrym_pkg::rshr(64'(raw_ff), 10),
                            vrym_pkg::V_MIN, vrym_pkg::V_MAX);
      k13  = 64'(dyaw_ff) * 64'(vrym_pkg::K1_GAIN) + 64'(k2_ff);
      x_w  = $signed(34'(vrym_pkg::STEER_OFS)
                     - 34'({22'd0, p_ff}) * 34'(vrym_pkg::STEER_SLOPE));
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      div_n = '0;
      div_d = '0;
      mul_st = 1'b0;
      div_st = 1'b0;
      unique case (state_ff)
         vrym_pkg::S_MT: begin
            mul_st = 1'b1;
            mul_a  = x_w;
            mul_b  = BW'(vrym_pkg::STEER_GAIN);
         end
         vrym_pkg::S_VV: begin
            mul_st = 1'b1;
            mul_a  = AW'(v_ff);
            mul_b  = v_ff;
         end
         vrym_pkg::S_KD: begin
            mul_st = 1'b1;
            mul_a  = AW'(dyaw_ff);
            mul_b  = BW'(k4_ff);
         end
         vrym_pkg::S_NS: begin
            mul_st = 1'b1;
            mul_a  = AW'(num_ff);
            mul_b  = BW'(steer_ff);
         end
         vrym_pkg::S_D180: begin
            div_st = 1'b1;
            div_n  = NW'(mul_p);
            div_d  = DW'(vrym_pkg::STEER_DIV);
         end
         vrym_pkg::S_K2: begin
            div_st = 1'b1;
            div_n  = NW'(vrym_pkg::K2_NUM);
            div_d  = DW'(v_ff);
         end
         vrym_pkg::S_K4: begin
            div_st = 1'b1;
            div_n  = NW'(vrym_pkg::K4_NUM);
            div_d  = DW'(v_ff);
         end
         vrym_pkg::S_K5: begin
            div_st = 1'b1;
            div_n  = NW'(vv_ff) * NW'(vrym_pkg::K5_GAIN) + NW'(vrym_pkg::K5_OFS);
            div_d  = vv_ff;
         end
         vrym_pkg::S_DY: begin
            div_st = 1'b1;
            div_n  = NW'(mul_p);
            div_d  = DW'(den_ff);
         end
         default: begin
            mul_st = 1'b0;
         end
      endcase
   end

   assign mul_start = mul_st && !launch_ff;
   assign div_start = div_st && !launch_ff;

   vrym_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_p)
   );

   vrym_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_n),
      .den   (div_d),
      .done  (div_done),
      .quot  (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vrym_pkg::S_IDLE;
         launch_ff    <= 1'b0;
         prev_ff      <= '0;
         raw_ff       <= '0;
         sc_ff        <= '0;
         y0_ff        <= '0;
         y1_ff        <= '0;
      end else begin
         if (mul_start || div_start) begin
            launch_ff <= 1'b1;
         end
         unique case (state_ff)
            vrym_pkg::S_IDLE: begin
               if (accept) begin
                  sc_ff    <= sc_in;
                  raw_ff   <= raw_in;
                  prev_ff  <= req_accel_sample;
                  p_ff     <= p_in;
                  state_ff <= vrym_pkg::S_VEL;
               end
            end
            vrym_pkg::S_VEL: begin
               v_ff    <= 22'(v_in);
               dyaw_ff <= 33'(vrym_pkg::rshr(64'(y1_ff) - 64'(y0_ff), 1));
               num_ff  <= '0;
               den_ff  <= '0;
               yaw_ff  <= '0;
               inv_ff  <= (v_in == '0);
               state_ff <= (v_in == '0) ? vrym_pkg::S_FIN : vrym_pkg::S_MT;
            end
            vrym_pkg::S_MT: begin
               if (mul_done) begin
                  launch_ff <= 1'b0;
                  state_ff  <= vrym_pkg::S_D180;
               end
            end
            vrym_pkg::S_D180: begin
               if (div_done) begin
                  launch_ff <= 1'b0;
                  steer_ff  <= 11'(vrym_pkg::rshr(64'(div_q), 10));
                  state_ff  <= vrym_pkg::S_VV;
               end
            end
            vrym_pkg::S_VV: begin
               if (mul_done) begin
                  launch_ff <= 1'b0;
                  vv_ff     <= 44'(mul_p);
                  state_ff  <= vrym_pkg::S_K2;
               end
            end
            vrym_pkg::S_K2: begin
               if (div_done) begin
                  launch_ff <= 1'b0;
                  k2_ff     <= 11'(div_q);
                  state_ff  <= vrym_pkg::S_K4;
               end
            end
            vrym_pkg::S_K4: begin
               if (div_done) begin
                  launch_ff <= 1'b0;
                  k4_ff     <= 5'(div_q);
                  state_ff  <= vrym_pkg::S_K5;
               end
            end
            vrym_pkg::S_K5: begin
               if (div_done) begin
                  launch_ff <= 1'b0;
                  k5_ff     <= 10'(div_q);
                  state_ff  <= vrym_pkg::S_KD;
               end
            end
            vrym_pkg::S_KD: begin
               if (mul_done) begin
                  launch_ff <= 1'b0;
                  num_ff    <= 32'(vrym_pkg::satr(k13, vrym_pkg::I32_MIN,
                                                  vrym_pkg::I32_MAX));
                  den_ff    <= 32'(vrym_pkg::satr(64'(mul_p) + 64'(k5_ff),
                                                  vrym_pkg::I32_MIN,
                                                  vrym_pkg::I32_MAX));
                  state_ff  <= vrym_pkg::S_ND;
               end
            end
            vrym_pkg::S_ND: begin
               if (den_ff == '0) begin
                  inv_ff   <= 1'b1;
                  state_ff <= vrym_pkg::S_FIN;
               end else begin
                  state_ff <= vrym_pkg::S_NS;
               end
            end
            vrym_pkg::S_NS: begin
               if (mul_done) begin
                  launch_ff <= 1'b0;
                  state_ff  <= vrym_pkg::S_DY;
               end
            end
            vrym_pkg::S_DY: begin
               if (div_done) begin
                  launch_ff <= 1'b0;
                  yaw_ff    <= 32'(vrym_pkg::satr(vrym_pkg::rshr(64'(div_q), 10),
                                                  vrym_pkg::I32_MIN,
                                                  vrym_pkg::I32_MAX));
                  state_ff  <= vrym_pkg::S_FIN;
               end
            end
            vrym_pkg::S_FIN: begin
               if (out_free) begin
                  y0_ff        <= y1_ff;
                  y1_ff        <= yaw_ff;
                  state_ff     <= vrym_pkg::S_IDLE;
               end
            end
            default: begin
               state_ff <= vrym_pkg::S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == vrym_pkg::S_FIN && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == vrym_pkg::S_FIN && out_free) begin
         rsp_vel_ff <= v_ff;
         rsp_yaw_ff <= yaw_ff;
         rsp_num_ff <= num_ff;
         rsp_den_ff <= den_ff;
         rsp_inv_ff <= inv_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_velocity        = rsp_vel_ff;
   assign rsp_reference_yaw   = rsp_yaw_ff;
   assign rsp_yaw_numerator   = rsp_num_ff;
   assign rsp_yaw_denominator = rsp_den_ff;
   assign rsp_model_invalid   = rsp_inv_ff;

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(mul_start && div_start))
      else $error("multiplier and divider started together");

   a_done_launched: assert property (@(posedge clock) disable iff (reset)
      (mul_done || div_done) |-> launch_ff)
      else $error("unit finished without a launch");

   a_fin_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vrym_pkg::S_FIN && out_free) |=> rsp_valid_ff)
      else $error("result not presented");

   a_valid_model: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_inv_ff) |-> (rsp_vel_ff != '0 && rsp_den_ff != '0))
      else $error("valid model with zero velocity or denominator");

endmodule
